// ----- src/ppo_pkg.sv -----
// ppo_pkg: types, mode codes and gamma table for the pixel point operation block
// no dependencies

package ppo_pkg;

    localparam int unsigned MODE_W = 3;

    localparam logic [MODE_W-1:0] MODE_RED    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_GREEN  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_BLUE   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_GREY   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_INVERT = 3'd4;
    localparam logic [MODE_W-1:0] MODE_GAMMA  = 3'd5;

    // reciprocal of three for the greyscale average: floor(x * 683 / 2048) == x / 3
    localparam logic [9:0] RECIP3       = 10'd683;
    localparam int unsigned RECIP3_SHIFT = 11;

    typedef logic [7:0] t_chan;
    typedef logic [255:0][7:0] t_lut;

    typedef struct packed {
        t_chan red;
        t_chan green;
        t_chan blue;
        logic  eof;
    } t_pix;

    typedef struct packed {
        t_pix       pix;
        t_pix       inv;
        t_pix       gam;
        logic [9:0] sum;
    } t_stage_a;

    typedef struct packed {
        t_pix  pix;
        t_pix  inv;
        t_pix  gam;
        t_chan avg;
    } t_stage_b;

    // largest y with y^11 <= v^5 * 255^6, found by binary search
    function automatic t_chan gamma_calc(input t_chan v);
        logic [95:0] rhs;
        logic [95:0] lhs;
        t_chan       y;
        t_chan       cand;
        rhs = 96'd1;
        y   = 8'd0;
        for (int k = 0; k < 5; k++) begin
            rhs = rhs * {88'd0, v};
        end
        for (int k = 0; k < 6; k++) begin
            rhs = rhs * 96'd255;
        end
        for (int b = 7; b >= 0; b--) begin
            cand = y | (8'd1 << b);
            lhs  = 96'd1;
            for (int k = 0; k < 11; k++) begin
                lhs = lhs * {88'd0, cand};
            end
            if (lhs <= rhs) begin
                y = cand;
            end
        end
        return y;
    endfunction

    function automatic t_lut gamma_table();
        t_lut t;
        for (int i = 0; i < 256; i++) begin
            t[i] = gamma_calc(i[7:0]);
        end
        return t;
    endfunction

    localparam t_lut GAMMA_LUT = gamma_table();

endpackage

// ----- src/pixel_point_operation.sv -----
// pixel_point_operation: top level, mode register and three-stage pixel pipeline
// depends on ppo_pkg, ppo_stage_a, ppo_stage_b, ppo_stage_c

// One RGB pixel enters per clock while the output is not stalled and passes
// through three pipeline registers (sum, invert and gamma lookup; divide by three;
// mode select). A stall on the output holds the pipeline and reaches the input
// only once all three stages are full. The mode register (0 red, 1 green, 2 blue,
// 3 greyscale, 4 invert, 5 gamma, other codes pass the pixel through) is written
// through the config channel, whose ready is always high; the user must write it
// only while no pixel is in flight, which the block itself does not enforce.

module pixel_point_operation
    import ppo_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [7:0]        i_red_in,
    input  logic [7:0]        i_green_in,
    input  logic [7:0]        i_blue_in,
    input  logic              i_end_of_frame_in,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [7:0]        o_red_out,
    output logic [7:0]        o_green_out,
    output logic [7:0]        o_blue_out,
    output logic              o_end_of_frame_out,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [MODE_W-1:0] i_cfg_data
);

    logic [MODE_W-1:0] r_mode;
    t_pix              in_pix;
    t_pix              out_pix;
    t_stage_a          a_data;
    t_stage_b          b_data;
    logic              a_ready;
    logic              a_valid;
    logic              b_ready;
    logic              b_valid;
    logic              c_ready;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_RED;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_mode <= i_cfg_data;
        end
    end

    assign in_pix.red   = i_red_in;
    assign in_pix.green = i_green_in;
    assign in_pix.blue  = i_blue_in;
    assign in_pix.eof   = i_end_of_frame_in;

    ppo_stage_a u_stage_a (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .i_pix        (in_pix),
        .i_ready_next (b_ready),
        .o_ready      (a_ready),
        .o_valid      (a_valid),
        .o_data       (a_data)
    );

    ppo_stage_b u_stage_b (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (a_valid),
        .i_data       (a_data),
        .i_ready_next (c_ready),
        .o_ready      (b_ready),
        .o_valid      (b_valid),
        .o_data       (b_data)
    );

    ppo_stage_c u_stage_c (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (b_valid),
        .i_data       (b_data),
        .i_mode       (r_mode),
        .i_ready_next (!i_out_stall),
        .o_ready      (c_ready),
        .o_valid      (o_out_valid),
        .o_pix        (out_pix)
    );

    assign o_in_stall         = !a_ready;
    assign o_red_out          = out_pix.red;
    assign o_green_out        = out_pix.green;
    assign o_blue_out         = out_pix.blue;
    assign o_end_of_frame_out = out_pix.eof;

`ifndef SYNTHESIS
    // input stalls only when every stage holds a beat and the output is stalled
    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (a_valid && b_valid && o_out_valid && i_out_stall))
        else $error("input stalled with a bubble in the pipeline");

    a_grey_equal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && r_mode == MODE_GREY) |->
            (o_red_out == o_green_out && o_green_out == o_blue_out))
        else $error("greyscale beat with unequal channels");

    a_red_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && r_mode == MODE_RED) |-> (o_green_out == 8'd0 && o_blue_out == 8'd0))
        else $error("red-only beat with nonzero green or blue");
`endif

endmodule

// ----- src/ppo_stage_a.sv -----
// ppo_stage_a: first pipeline stage, channel sum, invert and gamma lookups
// depends on ppo_pkg

module ppo_stage_a
    import ppo_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_pix     i_pix,
    input  logic     i_ready_next,
    output logic     o_ready,
    output logic     o_valid,
    output t_stage_a o_data
);

    logic     r_valid;
    t_stage_a r_data;
    t_stage_a n_data;

    assign o_ready = !r_valid || i_ready_next;

    always_comb begin
        n_data.pix       = i_pix;
        n_data.inv.red   = 8'd255 - i_pix.red;
        n_data.inv.green = 8'd255 - i_pix.green;
        n_data.inv.blue  = 8'd255 - i_pix.blue;
        n_data.inv.eof   = i_pix.eof;
        n_data.gam.red   = GAMMA_LUT[i_pix.red];
        n_data.gam.green = GAMMA_LUT[i_pix.green];
        n_data.gam.blue  = GAMMA_LUT[i_pix.blue];
        n_data.gam.eof   = i_pix.eof;
        n_data.sum       = {2'b00, i_pix.red} + {2'b00, i_pix.green} + {2'b00, i_pix.blue};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ----- src/ppo_stage_b.sv -----
// ppo_stage_b: second pipeline stage, divides the channel sum by three
// depends on ppo_pkg

module ppo_stage_b
    import ppo_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_stage_a i_data,
    input  logic     i_ready_next,
    output logic     o_ready,
    output logic     o_valid,
    output t_stage_b o_data
);

    logic        r_valid;
    t_stage_b    r_data;
    t_stage_b    n_data;
    logic [19:0] prod;

    assign o_ready = !r_valid || i_ready_next;
    assign prod    = i_data.sum * RECIP3;

    always_comb begin
        n_data.pix = i_data.pix;
        n_data.inv = i_data.inv;
        n_data.gam = i_data.gam;
        n_data.avg = prod[RECIP3_SHIFT +: 8];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ----- src/ppo_stage_c.sv -----
// ppo_stage_c: last pipeline stage, picks the result for the mode into the output register
// depends on ppo_pkg

module ppo_stage_c
    import ppo_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  t_stage_b          i_data,
    input  logic [MODE_W-1:0] i_mode,
    input  logic              i_ready_next,
    output logic              o_ready,
    output logic              o_valid,
    output t_pix              o_pix
);

    logic r_valid;
    t_pix r_pix;
    t_pix n_pix;

    assign o_ready = !r_valid || i_ready_next;

    always_comb begin
        n_pix = i_data.pix;
        unique case (i_mode)
            MODE_RED: begin
                n_pix.green = 8'd0;
                n_pix.blue  = 8'd0;
            end
            MODE_GREEN: begin
                n_pix.red  = 8'd0;
                n_pix.blue = 8'd0;
            end
            MODE_BLUE: begin
                n_pix.red   = 8'd0;
                n_pix.green = 8'd0;
            end
            MODE_GREY: begin
                n_pix.red   = i_data.avg;
                n_pix.green = i_data.avg;
                n_pix.blue  = i_data.avg;
            end
            MODE_INVERT: begin
                n_pix = i_data.inv;
            end
            MODE_GAMMA: begin
                n_pix = i_data.gam;
            end
            default: begin
                n_pix = i_data.pix;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_pix <= n_pix;
        end
    end

    assign o_valid = r_valid;
    assign o_pix   = r_pix;

endmodule

// ----- tb/pixel_point_operation_tb.sv -----
// pixel_point_operation_tb: self-checking bench for the pixel point operation block
// streams pixels under every mode, with random valid/stall bursts in most phases, checks each beat
// against an in-bench predictor; depends on ppo_pkg and pixel_point_operation

module pixel_point_operation_tb;
    import ppo_pkg::*;

    localparam logic [MODE_W-1:0] MODE_PASS_A = 3'd6;
    localparam logic [MODE_W-1:0] MODE_PASS_B = 3'd7;

    localparam int RESET_CYCLES  = 5;
    localparam int SETTLE_CYCLES = 6;
    localparam int PHASES        = 16;
    localparam int PHASE_ITEMS   = 109;
    localparam int QUIET_LIMIT   = 2000;

    logic              i_clk;
    logic              i_rst_n            = 1'b0;
    logic              i_in_valid         = 1'b0;
    logic              o_in_stall;
    logic [7:0]        i_red_in           = 8'd0;
    logic [7:0]        i_green_in         = 8'd0;
    logic [7:0]        i_blue_in          = 8'd0;
    logic              i_end_of_frame_in  = 1'b0;
    logic              o_out_valid;
    logic              i_out_stall        = 1'b0;
    logic [7:0]        o_red_out;
    logic [7:0]        o_green_out;
    logic [7:0]        o_blue_out;
    logic              o_end_of_frame_out;
    logic              i_cfg_valid        = 1'b0;
    logic              o_cfg_ready;
    logic [MODE_W-1:0] i_cfg_data         = '0;

    t_chan             gamma_rom [256];
    t_pix              pending_pixels [$];
    t_pix              predicted_pixels [$];
    t_pix              sent_pix;
    t_pix              want;
    logic [MODE_W-1:0] cur_mode           = MODE_RED;
    logic [7:0]        modes_seen         = 8'd0;
    bit                bursts_enabled     = 1'b1;
    int                send_gap           = 0;
    int                stall_left         = 0;
    int                quiet_cycles       = 0;
    int                beats_in           = 0;
    int                beats_out          = 0;
    int                errors             = 0;

    pixel_point_operation dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_red_in           (i_red_in),
        .i_green_in         (i_green_in),
        .i_blue_in          (i_blue_in),
        .i_end_of_frame_in  (i_end_of_frame_in),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_red_out          (o_red_out),
        .o_green_out        (o_green_out),
        .o_blue_out         (o_blue_out),
        .o_end_of_frame_out (o_end_of_frame_out),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_data         (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [95:0] int_pow(input int base, input int n);
        logic [95:0] acc;
        acc = 96'd1;
        for (int k = 0; k < n; k++) begin
            acc = acc * 96'(base);
        end
        return acc;
    endfunction

    // y = floor(255 * (v/255)^(1/2.2)), i.e. largest y with y^11 <= v^5 * 255^6
    initial begin : gamma_fill
        logic [95:0] bound;
        int          y;
        y = 0;
        for (int v = 0; v < 256; v++) begin
            bound = int_pow(v, 5) * int_pow(255, 6);
            while (y < 255 && int_pow(y + 1, 11) <= bound) begin
                y++;
            end
            gamma_rom[v] = 8'(y);
        end
    end

    function automatic t_pix point_op(input t_pix p, input logic [MODE_W-1:0] m);
        t_pix       q;
        logic [9:0] sum;
        q   = p;
        sum = 10'(p.red) + 10'(p.green) + 10'(p.blue);
        case (m)
            MODE_RED: begin
                q.green = 8'd0;
                q.blue  = 8'd0;
            end
            MODE_GREEN: begin
                q.red  = 8'd0;
                q.blue = 8'd0;
            end
            MODE_BLUE: begin
                q.red   = 8'd0;
                q.green = 8'd0;
            end
            MODE_GREY: begin
                q.red   = 8'(sum / 10'd3);
                q.green = q.red;
                q.blue  = q.red;
            end
            MODE_INVERT: begin
                q.red   = 8'd255 - p.red;
                q.green = 8'd255 - p.green;
                q.blue  = 8'd255 - p.blue;
            end
            MODE_GAMMA: begin
                q.red   = gamma_rom[p.red];
                q.green = gamma_rom[p.green];
                q.blue  = gamma_rom[p.blue];
            end
            default: begin
            end
        endcase
        return q;
    endfunction

    // input side: accepted beats feed the predictor, idle bursts between beats
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                predicted_pixels.push_back(point_op(sent_pix, cur_mode));
                beats_in++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (bursts_enabled && $urandom_range(0, 9) == 0) begin
                    send_gap = $urandom_range(0, 9);
                    i_in_valid <= 1'b0;
                end else if (pending_pixels.size() != 0) begin
                    sent_pix = pending_pixels.pop_front();
                    i_in_valid        <= 1'b1;
                    i_red_in          <= sent_pix.red;
                    i_green_in        <= sent_pix.green;
                    i_blue_in         <= sent_pix.blue;
                    i_end_of_frame_in <= sent_pix.eof;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // output side: compare each beat with the oldest prediction, random stall bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                beats_out++;
                if (predicted_pixels.size() == 0) begin
                    $error("output beat with nothing expected");
                    errors++;
                end else begin
                    want = predicted_pixels.pop_front();
                    if (o_red_out !== want.red) begin
                        $error("red_out: expected %0d, got %0d", want.red, o_red_out);
                        errors++;
                    end
                    if (o_green_out !== want.green) begin
                        $error("green_out: expected %0d, got %0d", want.green, o_green_out);
                        errors++;
                    end
                    if (o_blue_out !== want.blue) begin
                        $error("blue_out: expected %0d, got %0d", want.blue, o_blue_out);
                        errors++;
                    end
                    if (o_end_of_frame_out !== want.eof) begin
                        $error("end_of_frame_out: expected %0d, got %0d", want.eof,
                               o_end_of_frame_out);
                        errors++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if (bursts_enabled && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 9);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("simulation failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic set_mode(input logic [MODE_W-1:0] m);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= m;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        cur_mode = m;
        modes_seen[m] = 1'b1;
    endtask

    task automatic queue_pixel(input t_chan r, input t_chan g, input t_chan b,
                               input logic eof);
        t_pix p;
        p.red   = r;
        p.green = g;
        p.blue  = b;
        p.eof   = eof;
        pending_pixels.push_back(p);
    endtask

    function automatic t_chan rand_chan();
        if ($urandom_range(0, 7) == 0) begin
            return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // wait until every queued pixel has gone in and every prediction has come out
    task automatic drain();
        @(negedge i_clk);
        while (pending_pixels.size() != 0 || i_in_valid || predicted_pixels.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    initial begin : stimulus
        logic [MODE_W-1:0] plan [8];
        plan = '{MODE_RED, MODE_GREEN, MODE_BLUE, MODE_GREY,
                 MODE_INVERT, MODE_GAMMA, MODE_PASS_A, MODE_PASS_B};
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // extremes and a mixed pixel under every mode code, spare codes included
        for (int m = 0; m < 8; m++) begin
            set_mode(plan[m]);
            @(negedge i_clk);
            queue_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
            queue_pixel(8'h00, 8'h00, 8'h00, 1'b0);
            queue_pixel(8'hA5, 8'h5A, 8'h01, m[0]);
            drain();
        end

        for (int p = 0; p < PHASES; p++) begin
            set_mode(p < 8 ? plan[p] : plan[$urandom_range(0, 7)]);
            @(negedge i_clk);
            bursts_enabled = (p != 5) && (p != PHASES - 1);
            repeat (PHASE_ITEMS) begin
                queue_pixel(rand_chan(), rand_chan(), rand_chan(),
                            $urandom_range(0, 15) == 0);
            end
            drain();
        end

        if (predicted_pixels.size() != 0) begin
            $error("%0d expected pixels never came out", predicted_pixels.size());
            errors++;
        end
        $display("covered %0d pixels in, %0d pixels checked, mode codes seen %b",
                 beats_in, beats_out, modes_seen);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
src/ppo_pkg.sv
src/ppo_stage_a.sv
src/ppo_stage_b.sv
src/ppo_stage_c.sv
src/pixel_point_operation.sv
tb/pixel_point_operation_tb.sv
